[rtl/lrpe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpe_pkg
// Types, sizes and codes shared by the LR parse engine modules.
// ----------------------------------------------------------------------------
package lrpe_pkg;

    localparam int NUM_STATES      = 256;
    localparam int NUM_SYMBOLS     = 64;
    localparam int STACK_DEPTH     = 64;
    localparam int NUM_PRODUCTIONS = 128;
    localparam int MAX_REDUCES     = 63;

    localparam int AG_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int AG_AW    = (AG_DEPTH > 1) ? $clog2(AG_DEPTH) : 1;
    localparam int PR_AW    = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
    localparam int STK_AW   = $clog2(STACK_DEPTH);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int RED_W    = $clog2(MAX_REDUCES + 1);

    typedef enum logic [1:0] {
        K_LOAD_ENTRY = 2'd0,
        K_LOAD_PROD  = 2'd1,
        K_START      = 2'd2,
        K_TOKEN      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        A_ERROR  = 2'd0,
        A_SHIFT  = 2'd1,
        A_REDUCE = 2'd2,
        A_ACCEPT = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        EV_SHIFT  = 2'd0,
        EV_REDUCE = 2'd1,
        EV_ACCEPT = 2'd2,
        EV_ERROR  = 2'd3
    } t_ev;

    typedef enum logic [2:0] {
        C_NONE       = 3'd0,
        C_ENTRY      = 3'd1,
        C_OVERFLOW   = 3'd2,
        C_UNDERFLOW  = 3'd3,
        C_REDUCE_LIM = 3'd4,
        C_NOT_ACTIVE = 3'd5
    } t_cause;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ACT,
        S_PROD,
        S_POP,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] state_index;
        logic [5:0] symbol;
        logic [1:0] action_code;
        logic [7:0] entry_value;
        logic [6:0] production_index;
        logic [3:0] rhs_length;
        logic [5:0] lhs_symbol;
    } t_cmd;

    typedef struct packed {
        t_ev        event_res;
        logic [7:0] event_value;
        t_cause     error_cause;
        logic [6:0] stack_depth;
        logic       last;
    } t_res;

endpackage
`default_nettype wire

[rtl/lrpe_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrpe_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                       i_wdata,
    input  wire logic                               i_re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                       o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/lrpe_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpe_front
// Accepts input items, drops skipped ones and queues commands (2 deep).
// ----------------------------------------------------------------------------
module lrpe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire lrpe_pkg::t_cmd i_cmd,
    input  wire logic          i_undef,
    output logic               o_cmd_valid,
    output lrpe_pkg::t_cmd     o_cmd,
    input  wire logic          i_cmd_pop
);
    import lrpe_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       keep, push;

    always_comb begin
        unique case (i_cmd.kind)
            K_LOAD_ENTRY: keep = (32'(i_cmd.state_index) < NUM_STATES) &&
                                 (32'(i_cmd.symbol) < NUM_SYMBOLS);
            K_LOAD_PROD:  keep = 32'(i_cmd.production_index) < NUM_PRODUCTIONS;
            K_START:      keep = 1'b1;
            K_TOKEN:      keep = !i_undef;
            default:      keep = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ i_cmd_pop;
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

[rtl/lrpe_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpe_back
// Executes queued commands: table loads, parse start and token steps.
// ----------------------------------------------------------------------------
module lrpe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire lrpe_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output lrpe_pkg::t_res      o_res
);
    import lrpe_pkg::*;

    t_state             r_state, n_state;
    logic [SP_W-1:0]    r_sp, n_sp;
    logic               r_active, n_active;
    logic [7:0]         r_top, n_top;
    logic [5:0]         r_sym, n_sym;
    logic [RED_W-1:0]   r_red, n_red;
    logic [7:0]         r_val, n_val;
    logic [3:0]         r_len, n_len;
    logic [5:0]         r_ls, n_ls;
    logic               r_ovalid, n_ovalid;
    t_res               r_res, n_res;

    logic               ag_we, ag_re, pr_we, pr_re, stk_we, stk_re;
    logic [AG_AW-1:0]   ag_waddr, ag_raddr;
    logic [9:0]         ag_rdata, pr_rdata;
    logic [PR_AW-1:0]   pr_raddr;
    logic [STK_AW-1:0]  stk_waddr, stk_raddr;
    logic [7:0]         stk_wdata, stk_rdata;
    logic               out_free, want_fail;
    t_cause             fail_cause;
    t_act               act;
    logic [3:0]         plen;
    logic [SP_W-1:0]    base;

    lrpe_ram #(.W(10), .D(AG_DEPTH)) u_ag (
        .i_clk, .i_we(ag_we), .i_waddr(ag_waddr),
        .i_wdata({i_cmd.action_code, i_cmd.entry_value}),
        .i_re(ag_re), .i_raddr(ag_raddr), .o_rdata(ag_rdata)
    );

    lrpe_ram #(.W(10), .D(NUM_PRODUCTIONS)) u_prod (
        .i_clk, .i_we(pr_we), .i_waddr(PR_AW'(i_cmd.production_index)),
        .i_wdata({i_cmd.rhs_length, i_cmd.lhs_symbol}),
        .i_re(pr_re), .i_raddr(pr_raddr), .o_rdata(pr_rdata)
    );

    lrpe_ram #(.W(8), .D(STACK_DEPTH)) u_stk (
        .i_clk, .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    assign out_free = !r_ovalid || i_ready;
    assign act      = t_act'(ag_rdata[9:8]);
    assign plen     = pr_rdata[9:6];
    assign base     = r_sp - SP_W'(r_len);
    assign ag_waddr = AG_AW'(32'(i_cmd.state_index) * NUM_SYMBOLS + 32'(i_cmd.symbol));
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;

    always_comb begin
        n_state    = r_state;
        n_sp       = r_sp;
        n_active   = r_active;
        n_top      = r_top;
        n_sym      = r_sym;
        n_red      = r_red;
        n_val      = r_val;
        n_len      = r_len;
        n_ls       = r_ls;
        n_ovalid   = r_ovalid && !i_ready;
        n_res      = r_res;
        o_cmd_pop  = 1'b0;
        ag_we      = 1'b0;
        ag_re      = 1'b0;
        ag_raddr   = AG_AW'(32'(r_top) * NUM_SYMBOLS + 32'(r_sym));
        pr_we      = 1'b0;
        pr_re      = 1'b0;
        pr_raddr   = PR_AW'(ag_rdata[7:0]);
        stk_we     = 1'b0;
        stk_waddr  = r_sp[STK_AW-1:0];
        stk_wdata  = ag_rdata[7:0];
        stk_re     = 1'b0;
        stk_raddr  = STK_AW'(r_sp - SP_W'(plen) - SP_W'(1));
        want_fail  = 1'b0;
        fail_cause = C_ENTRY;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_LOAD_ENTRY: begin
                            ag_we     = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        K_LOAD_PROD: begin
                            pr_we     = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        K_START: begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = 8'd0;
                            n_sp      = SP_W'(1);
                            n_active  = 1'b1;
                            n_top     = 8'd0;
                            o_cmd_pop = 1'b1;
                        end
                        K_TOKEN: begin
                            if (!r_active || r_sp == '0 || 32'(r_sp) > STACK_DEPTH) begin
                                want_fail  = 1'b1;
                                fail_cause = C_NOT_ACTIVE;
                                o_cmd_pop  = out_free;
                            end else begin
                                n_sym     = i_cmd.symbol;
                                n_red     = '0;
                                o_cmd_pop = 1'b1;
                                n_state   = S_LOOK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOK: begin
                ag_re   = 1'b1;
                n_state = S_ACT;
            end
            S_ACT: begin
                if (32'(r_top) >= NUM_STATES || 32'(r_sym) >= NUM_SYMBOLS) begin
                    want_fail = 1'b1;
                end else begin
                    unique case (act)
                        A_SHIFT: begin
                            if (32'(r_sp) >= STACK_DEPTH) begin
                                want_fail  = 1'b1;
                                fail_cause = C_OVERFLOW;
                            end else if (out_free) begin
                                stk_we   = 1'b1;
                                n_sp     = r_sp + SP_W'(1);
                                n_top    = ag_rdata[7:0];
                                n_ovalid = 1'b1;
                                n_res    = '{EV_SHIFT, ag_rdata[7:0], C_NONE,
                                             7'(r_sp + SP_W'(1)), 1'b1};
                                n_state  = S_IDLE;
                            end
                        end
                        A_REDUCE: begin
                            if (32'(r_red) >= MAX_REDUCES) begin
                                want_fail  = 1'b1;
                                fail_cause = C_REDUCE_LIM;
                            end else if (32'(ag_rdata[7:0]) >= NUM_PRODUCTIONS) begin
                                want_fail = 1'b1;
                            end else begin
                                pr_re   = 1'b1;
                                n_val   = ag_rdata[7:0];
                                n_state = S_PROD;
                            end
                        end
                        A_ACCEPT: begin
                            if (out_free) begin
                                n_active = 1'b0;
                                n_ovalid = 1'b1;
                                n_res    = '{EV_ACCEPT, 8'd0, C_NONE, 7'(r_sp), 1'b1};
                                n_state  = S_IDLE;
                            end
                        end
                        default: want_fail = 1'b1;
                    endcase
                end
            end
            S_PROD: begin
                if (16'(plen) >= 16'(r_sp)) begin
                    want_fail  = 1'b1;
                    fail_cause = C_UNDERFLOW;
                end else if (plen == 4'd0 && 32'(r_sp) >= STACK_DEPTH) begin
                    want_fail  = 1'b1;
                    fail_cause = C_OVERFLOW;
                end else begin
                    stk_re  = 1'b1;
                    n_len   = plen;
                    n_ls    = pr_rdata[5:0];
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (32'(stk_rdata) >= NUM_STATES || 32'(r_ls) >= NUM_SYMBOLS) begin
                    want_fail = 1'b1;
                end else begin
                    ag_re    = 1'b1;
                    ag_raddr = AG_AW'(32'(stk_rdata) * NUM_SYMBOLS + 32'(r_ls));
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    stk_we    = 1'b1;
                    stk_waddr = base[STK_AW-1:0];
                    n_sp      = base + SP_W'(1);
                    n_top     = ag_rdata[7:0];
                    n_red     = r_red + RED_W'(1);
                    n_ovalid  = 1'b1;
                    n_res     = '{EV_REDUCE, r_val, C_NONE, 7'(base + SP_W'(1)), 1'b0};
                    n_state   = S_LOOK;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (want_fail && out_free) begin
            n_active = 1'b0;
            n_ovalid = 1'b1;
            n_res    = '{EV_ERROR, 8'd0, fail_cause, 7'(r_sp), 1'b1};
            n_state  = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_sym <= n_sym;
        r_red <= n_red;
        r_val <= n_val;
        r_len <= n_len;
        r_ls  <= n_ls;
        r_res <= n_res;
    end
endmodule
`default_nettype wire

[rtl/lr_table_parse_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lr_table_parse_engine
// Table-driven LR shift-reduce parse engine with a stream interface.
// ----------------------------------------------------------------------------
// Items enter a two-deep command queue; undefined tokens and out-of-range
// loads are dropped there. The execution unit handles a load or start item
// in its idle state. A token fails at once when no parse is active; else it
// looks up the action table and shifts, accepts, fails or reduces: each
// reduction reads the action table, the production table, the state stack
// and the action table again, each a registered RAM read.
// Results wait in one output register.
module lr_table_parse_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // state_index[7:0] symbol[13:8] action_code[15:14] entry_value[23:16]
    // production_index[30:24] rhs_length[34:31] lhs_symbol[40:35], zero fill
    input  wire logic [47:0] s_axis_tdata,
    // kind[1:0] undefined_token[2]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_value[7:0] error_cause[10:8] stack_depth[17:11], zero fill
    output logic [23:0]      m_axis_tdata,
    // event_res[1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    import lrpe_pkg::*;

    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_pop;

    assign in_cmd = '{t_kind'(s_axis_tuser[1:0]), s_axis_tdata[7:0], s_axis_tdata[13:8],
                      s_axis_tdata[15:14], s_axis_tdata[23:16], s_axis_tdata[30:24],
                      s_axis_tdata[34:31], s_axis_tdata[40:35]};

    lrpe_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(in_cmd), .i_undef(s_axis_tuser[2]),
        .o_cmd_valid(q_valid), .o_cmd(q_cmd), .i_cmd_pop(q_pop)
    );

    lrpe_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(q_valid), .i_cmd(q_cmd), .o_cmd_pop(q_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {6'd0, res.stack_depth, res.error_cause, res.event_value};
    assign m_axis_tuser = res.event_res;
    assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

[rtl/lrpe_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpe_checker
// Port-level checks on the result stream of the parse engine.
// ----------------------------------------------------------------------------
module lrpe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import lrpe_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != EV_REDUCE |-> m_axis_tlast)
        else $error("final event without last");

    a_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == EV_REDUCE |->
            !m_axis_tlast && m_axis_tdata[10:8] == C_NONE)
        else $error("bad reduce event");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[17:11]) <= STACK_DEPTH)
        else $error("stack depth out of range");
endmodule

bind lr_table_parse_engine lrpe_checker u_lrpe_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

[tb/tb_lr_table_parse_engine.sv]
// ----------------------------------------------------------------------------
// tb_lr_table_parse_engine
// Self-checking bench for the LR parse engine: loads tables, starts parses
// and feeds tokens over the input stream. A predictor keeps its own copy of
// the tables and the state stack and queues the parse events each token must
// produce. Entries a token would read before they are loaded get loaded first.
// ----------------------------------------------------------------------------
`default_nettype none

import lrpe_pkg::*;

class parse_scoreboard;
    logic [9:0] agt_mem [AG_DEPTH];
    bit         agt_ok  [AG_DEPTH];
    logic [9:0] prod_mem [NUM_PRODUCTIONS];
    bit         prod_ok  [NUM_PRODUCTIONS];
    logic [7:0] stk [STACK_DEPTH];
    int         sp;
    bit         active;
    t_res       expected_q [$];
    int         mismatches;
    int         results_seen;

    function new();
        sp = 0;
        active = 0;
        mismatches = 0;
        results_seen = 0;
    endfunction

    function t_res mk(t_ev ev, logic [7:0] v, t_cause c, int d, bit l);
        t_res r;
        r.event_res   = ev;
        r.event_value = v;
        r.error_cause = c;
        r.stack_depth = d[6:0];
        r.last        = l;
        return r;
    endfunction

    // Returns -1 when the token is fully predictable, else the missing entry:
    // an action table index, or AG_DEPTH plus a production number.
    function int parse_token(logic [5:0] sym, bit commit);
        logic [7:0] lstk [STACK_DEPTH];
        int         lsp;
        bit         lact;
        bit         done;
        int         red;
        int         idx;
        int         gi;
        int         len;
        logic [5:0] ls;
        logic [9:0] e;
        logic [7:0] v;
        t_cause     cause;
        t_res       evq [$];
        lstk = stk;
        lsp  = sp;
        lact = active;
        done = 0;
        red  = 0;
        if (!lact || lsp == 0) begin
            evq = {evq, mk(EV_ERROR, 8'd0, C_NOT_ACTIVE, lsp, 1'b1)};
            lact = 0;
            done = 1;
        end
        while (!done) begin
            cause = C_NONE;
            idx = lstk[lsp-1] * NUM_SYMBOLS + sym;
            if (!agt_ok[idx]) return idx;
            e = agt_mem[idx];
            v = e[7:0];
            case (t_act'(e[9:8]))
                A_SHIFT: begin
                    if (lsp >= STACK_DEPTH) cause = C_OVERFLOW;
                    else begin
                        lstk[lsp] = v;
                        lsp++;
                        evq = {evq, mk(EV_SHIFT, v, C_NONE, lsp, 1'b1)};
                        done = 1;
                    end
                end
                A_REDUCE: begin
                    if (red >= MAX_REDUCES) cause = C_REDUCE_LIM;
                    else if (v >= NUM_PRODUCTIONS) cause = C_ENTRY;
                    else begin
                        if (!prod_ok[v]) return AG_DEPTH + v;
                        len = prod_mem[v][9:6];
                        ls  = prod_mem[v][5:0];
                        if (len >= lsp) cause = C_UNDERFLOW;
                        else if (len == 0 && lsp >= STACK_DEPTH) cause = C_OVERFLOW;
                        else begin
                            gi = lstk[lsp-len-1] * NUM_SYMBOLS + ls;
                            if (!agt_ok[gi]) return gi;
                            lsp -= len;
                            lstk[lsp] = agt_mem[gi][7:0];
                            lsp++;
                            evq = {evq, mk(EV_REDUCE, v, C_NONE, lsp, 1'b0)};
                            red++;
                        end
                    end
                end
                A_ACCEPT: begin
                    lact = 0;
                    evq = {evq, mk(EV_ACCEPT, 8'd0, C_NONE, lsp, 1'b1)};
                    done = 1;
                end
                default: cause = C_ENTRY;
            endcase
            if (cause != C_NONE) begin
                lact = 0;
                evq = {evq, mk(EV_ERROR, 8'd0, cause, lsp, 1'b1)};
                done = 1;
            end
        end
        if (commit) begin
            stk = lstk;
            sp = lsp;
            active = lact;
            expected_q = {expected_q, evq};
        end
        return -1;
    endfunction

    function void note_item(t_cmd c, bit undef);
        case (c.kind)
            K_LOAD_ENTRY: begin
                agt_mem[c.state_index * NUM_SYMBOLS + c.symbol] = {c.action_code, c.entry_value};
                agt_ok[c.state_index * NUM_SYMBOLS + c.symbol] = 1;
            end
            K_LOAD_PROD: begin
                prod_mem[c.production_index] = {c.rhs_length, c.lhs_symbol};
                prod_ok[c.production_index] = 1;
            end
            K_START: begin
                stk[0] = 0;
                sp = 1;
                active = 1;
            end
            default: if (!undef) void'(parse_token(c.symbol, 1));
        endcase
    endfunction

    function void check_result(t_res got);
        t_res want;
        results_seen++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result res=%0d val=%0d cause=%0d depth=%0d last=%0d",
                         got.event_res, got.event_value, got.error_cause,
                         got.stack_depth, got.last);
            return;
        end
        want = expected_q.pop_front();
        if (got.event_res !== want.event_res || got.event_value !== want.event_value ||
            got.error_cause !== want.error_cause || got.stack_depth !== want.stack_depth ||
            got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: res %0d/%0d val %0d/%0d cause %0d/%0d depth %0d/%0d last %0d/%0d (exp/act)",
                         want.event_res, got.event_res, want.event_value, got.event_value,
                         want.error_cause, got.error_cause, want.stack_depth,
                         got.stack_depth, want.last, got.last);
        end
    endfunction
endclass

module tb_lr_table_parse_engine;
    import lrpe_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int NUM_ITEMS  = 310;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    parse_scoreboard sb = new();
    int  idle_cycles = 0;
    int  items_sent = 0;
    int  tokens_sent = 0;
    bit  no_gaps = 0;

    lr_table_parse_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_cmd rand_cmd(t_kind k);
        t_cmd c;
        c = t_cmd'({$urandom, $urandom});
        c.kind = k;
        return c;
    endfunction

    function automatic logic [7:0] pick_state();
        return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    task automatic send_item(t_cmd c, bit undef);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {7'd0, c.lhs_symbol, c.rhs_length, c.production_index,
                          c.entry_value, c.action_code, c.symbol, c.state_index};
        s_axis_tuser  <= {undef, c.kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(c, undef);
        items_sent++;
    endtask

    task automatic load_entry(logic [7:0] st, logic [5:0] sym, t_act act, logic [7:0] val);
        t_cmd c;
        c = rand_cmd(K_LOAD_ENTRY);
        c.state_index = st;
        c.symbol = sym;
        c.action_code = act;
        c.entry_value = val;
        send_item(c, $urandom_range(0, 1));
    endtask

    task automatic load_prod(logic [6:0] p, logic [3:0] rhs, logic [5:0] lhs);
        t_cmd c;
        c = rand_cmd(K_LOAD_PROD);
        c.production_index = p;
        c.rhs_length = rhs;
        c.lhs_symbol = lhs;
        send_item(c, $urandom_range(0, 1));
    endtask

    task automatic start_parse();
        send_item(rand_cmd(K_START), $urandom_range(0, 1));
    endtask

    task automatic fill_entry(int idx);
        int     r;
        t_act   act;
        logic [7:0] val;
        r = $urandom_range(0, 15);
        act = (r == 0) ? A_ERROR : (r <= 8) ? A_SHIFT : (r <= 14) ? A_REDUCE : A_ACCEPT;
        case (act)
            A_SHIFT:  val = pick_state();
            A_REDUCE: val = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(128, 255))
                                                         : 8'($urandom_range(0, 15));
            default:  val = 8'($urandom);
        endcase
        load_entry(8'(idx / NUM_SYMBOLS), 6'(idx % NUM_SYMBOLS), act, val);
    endtask

    task automatic send_token(logic [5:0] sym);
        t_cmd c;
        int   missing;
        missing = sb.parse_token(sym, 0);
        while (missing >= 0) begin
            if (missing < AG_DEPTH) fill_entry(missing);
            else load_prod(7'(missing - AG_DEPTH),
                           ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)),
                           ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)));
            missing = sb.parse_token(sym, 0);
        end
        c = rand_cmd(K_TOKEN);
        c.symbol = sym;
        send_item(c, 0);
        tokens_sent++;
    endtask

    task automatic send_undefined();
        send_item(rand_cmd(K_TOKEN), 1);
    endtask

    always @(posedge i_clk) begin
        t_res got;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got.event_value = m_axis_tdata[7:0];
            got.error_cause = t_cause'(m_axis_tdata[10:8]);
            got.stack_depth = m_axis_tdata[17:11];
            got.event_res   = t_ev'(m_axis_tuser);
            got.last        = m_axis_tlast;
            sb.check_result(got);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 11);
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        send_token(6'd1);
        send_undefined();
        start_parse();
        load_entry(8'd255, 6'd63, A_ACCEPT, 8'd255);
        load_prod(7'd127, 4'd15, 6'd63);
        load_entry(8'd0, 6'd1, A_SHIFT, 8'd1);
        load_entry(8'd1, 6'd2, A_REDUCE, 8'd5);
        load_prod(7'd5, 4'd1, 6'd10);
        load_entry(8'd0, 6'd10, A_ACCEPT, 8'd2);
        load_entry(8'd2, 6'd3, A_ACCEPT, 8'd0);
        load_entry(8'd2, 6'd4, A_ERROR, 8'd0);
        send_token(6'd1);
        send_token(6'd2);
        send_token(6'd4);
        // reduce loop that never shifts: hits the reduce limit
        start_parse();
        load_entry(8'd0, 6'd12, A_SHIFT, 8'd8);
        load_entry(8'd8, 6'd9, A_REDUCE, 8'd9);
        load_prod(7'd9, 4'd1, 6'd11);
        load_entry(8'd0, 6'd11, A_SHIFT, 8'd8);
        send_token(6'd12);
        send_token(6'd9);
        // empty reductions fill the stack until it overflows
        start_parse();
        load_entry(8'd0, 6'd13, A_SHIFT, 8'd4);
        load_entry(8'd4, 6'd6, A_REDUCE, 8'd6);
        load_prod(7'd6, 4'd0, 6'd7);
        load_entry(8'd4, 6'd7, A_SHIFT, 8'd4);
        send_token(6'd13);
        send_token(6'd6);
        // long right side pops past the bottom
        start_parse();
        load_entry(8'd0, 6'd14, A_REDUCE, 8'd15);
        load_prod(7'd15, 4'd15, 6'd0);
        send_token(6'd14);
        start_parse();
        load_entry(8'd0, 6'd15, A_REDUCE, 8'd200);
        send_token(6'd15);

        while (items_sent < NUM_ITEMS) begin
            if (items_sent % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (!sb.active) begin
                if (r < 80) start_parse();
                else if (r < 90) send_token(6'($urandom));
                else if (r < 95) send_undefined();
                else fill_entry($urandom_range(0, AG_DEPTH - 1));
            end else if (r < 75) begin
                send_token(($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)));
            end else if (r < 85) begin
                fill_entry($urandom_range(0, 7) * NUM_SYMBOLS + $urandom_range(0, 7));
            end else if (r < 90) begin
                load_prod(7'($urandom_range(0, 15)), 4'($urandom_range(0, 3)),
                          6'($urandom_range(0, 7)));
            end else if (r < 95) begin
                send_undefined();
            end else if (r < 98) begin
                start_parse();
            end else begin
                load_prod(7'($urandom), 4'($urandom), 6'($urandom));
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 0;

        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        sb.mismatches += sb.expected_q.size();

        $display("Sent %0d items (%0d tokens), checked %0d parse events",
                 items_sent, tokens_sent, sb.results_seen);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
